// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL in this folder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/sacc_pkg.sv
// ---------------------------------------------------------------------------
// sacc_pkg
// Shared types and constants of the set-associative cache tag controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sacc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] CFG_WAYS        = 2'd2;

  // Configuration reset values
  localparam logic [3:0] RST_OFFSET_BITS = 4'd5;
  localparam logic [3:0] RST_INDEX_BITS  = 4'd6;
  localparam logic [3:0] RST_WAYS        = 4'd4;

  // Access kinds
  localparam logic OP_WRITE = 1'b1;

  // Request transaction
  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic        hit;
    logic [2:0]  way;
    logic        writeback_valid;
    logic [31:0] writeback_addr;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/core/sacc_row_ram.sv
// ---------------------------------------------------------------------------
// sacc_row_ram
// Set row memory: one row per set, one write and one read port, registered
// read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sacc_row_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int ROW_W  = 304
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [ROW_W-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sacc_way_logic.sv
// ---------------------------------------------------------------------------
// sacc_way_logic
// Lookup and update of one set row: tag match, fill way, LRU victim choice
// and the rank, valid, dirty and tag values written back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sacc_way_logic #(
  parameter int MAX_WAYS = 8,
  parameter int RANK_W   = 3,
  parameter int WAY_W    = 3,
  parameter int TAG_W    = 32
) (
  input  wire logic [MAX_WAYS-1:0]             valid,
  input  wire logic [MAX_WAYS-1:0]             dirty,
  input  wire logic [MAX_WAYS-1:0][RANK_W-1:0] rank,
  input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]  tag,
  input  wire logic [TAG_W-1:0]                req_tag,
  input  wire logic                            req_write,
  input  wire logic [4:0]                      nw,
  output logic                                 hit,
  output logic      [WAY_W-1:0]                sel,
  output logic                                 wb,
  output logic      [TAG_W-1:0]                wb_tag,
  output logic      [MAX_WAYS-1:0]             valid_next,
  output logic      [MAX_WAYS-1:0]             dirty_next,
  output logic      [MAX_WAYS-1:0][RANK_W-1:0] rank_next,
  output logic      [MAX_WAYS-1:0][TAG_W-1:0]  tag_next
);

  localparam logic [RANK_W-1:0] RANK_SAT  = RANK_W'(MAX_WAYS - 1);
  localparam logic [RANK_W:0]   RANK_NONE = (RANK_W + 1)'(MAX_WAYS);

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] empty;
  logic [MAX_WAYS-1:0] oldest;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    fill_way;
  logic [WAY_W-1:0]    vic_way;
  logic                any_empty;
  logic [RANK_W:0]     sel_rank;

  // Classify each way of the row
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      in_use[j] = (5'(j) < nw);
      match[j]  = in_use[j] && valid[j] && (tag[j] == req_tag);
      empty[j]  = in_use[j] && !valid[j];
    end
  end

  // Pick the oldest way in use, ties to the lowest way
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      oldest[j] = in_use[j];
      for (int k = 0; k < MAX_WAYS; k++) begin
        if (k != j && in_use[k]) begin
          if (k < j) begin
            if (rank[j] <= rank[k]) oldest[j] = 1'b0;
          end else begin
            if (rank[j] < rank[k]) oldest[j] = 1'b0;
          end
        end
      end
    end
  end

  // Encode the lowest way of each group
  always_comb begin
    hit_way  = '0;
    fill_way = '0;
    vic_way  = '0;
    for (int j = MAX_WAYS - 1; j >= 0; j--) begin
      if (match[j])  hit_way  = WAY_W'(j);
      if (empty[j])  fill_way = WAY_W'(j);
      if (oldest[j]) vic_way  = WAY_W'(j);
    end
  end

  assign hit       = |match;
  assign any_empty = |empty;
  assign sel       = hit ? hit_way : (any_empty ? fill_way : vic_way);
  assign wb        = !hit && !any_empty && dirty[sel];
  assign wb_tag    = tag[sel];
  assign sel_rank  = valid[sel] ? {1'b0, rank[sel]} : RANK_NONE;

  // Age younger ways, make the touched way most recent and fill on a miss
  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      valid_next[j] = valid[j];
      dirty_next[j] = dirty[j];
      rank_next[j]  = rank[j];
      tag_next[j]   = tag[j];
      if (WAY_W'(j) == sel) begin
        valid_next[j] = 1'b1;
        dirty_next[j] = hit ? (dirty[j] || req_write) : req_write;
        rank_next[j]  = '0;
        tag_next[j]   = req_tag;
      end else if (in_use[j] && valid[j] && ({1'b0, rank[j]} < sel_rank) &&
                   (rank[j] < RANK_SAT)) begin
        rank_next[j] = rank[j] + RANK_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/set_assoc_cache_tag_controller.sv
// Set-associative, write-back, write-allocate cache tag controller with LRU
// replacement. Each request transaction runs as follows: the cycle it is
// accepted reads the set row from a single-port-style row memory, and the
// lookup state then compares the tags, picks the hit, fill or victim way and
// writes the updated row back, loading the response register. A new request
// is not taken until the row read-modify-write of the last one is done. A
// response waits in its register without blocking the next request, but a
// second lookup holds while an unread response is stalled. After reset a
// clearing pass writes every row of the memory while in_stall stays high;
// configuration writes are taken at any time.
// ---------------------------------------------------------------------------
// set_assoc_cache_tag_controller
// Top level: configuration registers, address split, sequencer, row memory,
// way logic and response register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module set_assoc_cache_tag_controller #(
  parameter int MAX_SETS   = 1024,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sacc_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sacc_pkg::rsp_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [3:0]     cfg_wdata
);

  import sacc_pkg::*;

  localparam int AW      = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
  localparam int TAG_W   = AW;
  localparam int IB_MAX  = $clog2(MAX_SETS + 1) - 1;
  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W   = RANK_W;
  localparam int ENTRY_W = 2 + RANK_W + TAG_W;
  localparam int ROW_W   = MAX_WAYS * ENTRY_W;

  localparam logic [31:0]      AMASK    = 32'hFFFF_FFFF >> (32 - AW);
  localparam logic [4:0]       IB_LIM   = 5'(IB_MAX);
  localparam logic [4:0]       WAYS_LIM = 5'(MAX_WAYS);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(MAX_SETS - 1);

  // Sequencer states
  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [SET_W-1:0] clr_addr;

  logic [3:0] offset_bits;
  logic [3:0] set_bits;
  logic [3:0] ways;

  logic [31:0]      addr_m;
  logic [4:0]       ib_eff;
  logic [4:0]       nw_eff;
  logic [4:0]       sh_eff;
  logic [31:0]      tag_full;
  logic [31:0]      set_full;
  logic             in_accept;
  logic             lookup_go;

  logic             req_write;
  logic [TAG_W-1:0] req_tag;
  logic [SET_W-1:0] req_set;
  logic [3:0]       req_ob;
  logic [4:0]       req_sh;
  logic [4:0]       req_nw;

  logic             rd_en;
  logic [ROW_W-1:0] rd_row;
  logic             wr_en;
  logic [SET_W-1:0] wr_addr;
  logic [ROW_W-1:0] wr_row;
  logic [ROW_W-1:0] upd_row;

  logic [MAX_WAYS-1:0]             row_valid;
  logic [MAX_WAYS-1:0]             row_dirty;
  logic [MAX_WAYS-1:0][RANK_W-1:0] row_rank;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  row_tag;
  logic [MAX_WAYS-1:0]             upd_valid;
  logic [MAX_WAYS-1:0]             upd_dirty;
  logic [MAX_WAYS-1:0][RANK_W-1:0] upd_rank;
  logic [MAX_WAYS-1:0][TAG_W-1:0]  upd_tag;

  logic             lk_hit;
  logic [WAY_W-1:0] lk_sel;
  logic             lk_wb;
  logic [TAG_W-1:0] lk_wb_tag;
  logic [31:0]      wb_addr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= RST_OFFSET_BITS;
      set_bits    <= RST_INDEX_BITS;
      ways        <= RST_WAYS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET_BITS: offset_bits <= cfg_wdata;
        CFG_INDEX_BITS:  set_bits    <= cfg_wdata;
        CFG_WAYS:        ways        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective geometry
  assign ib_eff = ({1'b0, set_bits} > IB_LIM) ? IB_LIM : {1'b0, set_bits};
  assign nw_eff = (ways == 4'd0) ? 5'd1 :
                  (({1'b0, ways} > WAYS_LIM) ? WAYS_LIM : {1'b0, ways});
  assign sh_eff = {1'b0, offset_bits} + ib_eff;

  // Split the request address
  assign addr_m   = in_data.address & AMASK;
  assign tag_full = addr_m >> sh_eff;
  assign set_full = (addr_m >> offset_bits) & ~(32'hFFFF_FFFF << ib_eff);

  // Handshake
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign lookup_go = (state == ST_LOOKUP) && (!out_valid || !out_stall);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == SET_LAST) state_next = ST_IDLE;
      ST_IDLE:   if (in_accept) state_next = ST_LOOKUP;
      ST_LOOKUP: if (lookup_go) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + SET_W'(1);
      end
    end
  end

  // Capture the request fields
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_write <= (in_data.opcode == OP_WRITE);
      req_tag   <= TAG_W'(tag_full);
      req_set   <= SET_W'(set_full);
      req_ob    <= offset_bits;
      req_sh    <= sh_eff;
      req_nw    <= nw_eff;
    end
  end

  // Row memory: read on accept, write back on lookup or clear
  assign rd_en   = in_accept;
  assign wr_en   = (state == ST_CLEAR) || lookup_go;
  assign wr_addr = (state == ST_CLEAR) ? clr_addr : req_set;
  assign wr_row  = (state == ST_CLEAR) ? '0 : upd_row;

  sacc_row_ram #(
    .DEPTH  (MAX_SETS),
    .ADDR_W (SET_W),
    .ROW_W  (ROW_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (SET_W'(set_full)),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row)
  );

  // Unpack and pack the row, one entry per way: valid, dirty, rank, tag
  for (genvar g = 0; g < MAX_WAYS; g++) begin : g_row
    assign {row_valid[g], row_dirty[g], row_rank[g], row_tag[g]} =
        rd_row[g*ENTRY_W +: ENTRY_W];
    assign upd_row[g*ENTRY_W +: ENTRY_W] =
        {upd_valid[g], upd_dirty[g], upd_rank[g], upd_tag[g]};
  end

  sacc_way_logic #(
    .MAX_WAYS (MAX_WAYS),
    .RANK_W   (RANK_W),
    .WAY_W    (WAY_W),
    .TAG_W    (TAG_W)
  ) u_way (
    .valid      (row_valid),
    .dirty      (row_dirty),
    .rank       (row_rank),
    .tag        (row_tag),
    .req_tag    (req_tag),
    .req_write  (req_write),
    .nw         (req_nw),
    .hit        (lk_hit),
    .sel        (lk_sel),
    .wb         (lk_wb),
    .wb_tag     (lk_wb_tag),
    .valid_next (upd_valid),
    .dirty_next (upd_dirty),
    .rank_next  (upd_rank),
    .tag_next   (upd_tag)
  );

  // Rebuild the evicted block address
  assign wb_addr = lk_wb ? ((32'(lk_wb_tag) << req_sh) | (32'(req_set) << req_ob)) : 32'd0;

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lookup_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_go) begin
      out_data.hit             <= lk_hit;
      out_data.way             <= 3'(lk_sel);
      out_data.writeback_valid <= lk_wb;
      out_data.writeback_addr  <= wb_addr;
    end
  end

  // Assertions
  `ASSERT_IMPL(a_no_rw_overlap, clk, rst, wr_en, !rd_en)
  `ASSERT_NEXT(a_accept_lookup, clk, rst, in_accept, state == ST_LOOKUP)
  `ASSERT_NEXT(a_lookup_resp, clk, rst, lookup_go, out_valid)
  `ASSERT_IMPL(a_sel_in_use, clk, rst, state == ST_LOOKUP, 5'(lk_sel) < req_nw)

endmodule

`default_nettype wire
